// ----- src/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types, codes and widths of the button debouncer with long press.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Default number of button slots in the state memory
  localparam int NUM_BUTTONS_DEF = 8;
  // Pin and mask fields carry at most eight buttons
  localparam int MAX_BUTTONS     = 8;

  localparam int NOW_W       = 32;
  localparam int PINS_W      = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MS_W        = 16;
  localparam int COUNT_W     = 4;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LONG_PRESS = 3'd1,
    REG_REPEAT     = 3'd2,
    REG_COUNT      = 3'd3,
    REG_ENABLE     = 3'd4
  } cfg_reg_t;

  // Event codes on the result beat
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_CLICK        = 3'd2,
    EV_RELEASE_LONG = 3'd3,
    EV_LONG         = 3'd4,
    EV_REPEAT       = 3'd5
  } event_t;

  // Timing settings handed to the update logic
  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
    logic [MS_W-1:0] repeat_ms;
  } timing_t;

  // One button's record in the state memory
  typedef struct packed {
    logic             raw_previous;
    logic             debounced_pressed;
    logic             long_active;
    logic [NOW_W-1:0] change_time;
    logic [NOW_W-1:0] press_start_time;
    logic [NOW_W-1:0] repeat_time;
  } btn_state_t;

  // Record seen for a slot that was never written since reset
  localparam btn_state_t BTN_RESET = '{
    raw_previous:      1'b1,
    debounced_pressed: 1'b0,
    long_active:       1'b0,
    change_time:       '0,
    press_start_time:  '0,
    repeat_time:       '0
  };

endpackage

// ----- src/button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces up to eight active-low buttons and reports press, click,
// release-after-long, long-press and repeat events, one result per button.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one update beat: the millisecond time stamp and the raw
//   pin levels. For every button in use the block returns one m_axis beat,
//   in index order, with tlast on the final button. A disabled button still
//   gets a beat, with tuser set and no event.
//   Per-button state lives in a one-port-read RAM; each cycle reads the next
//   button while the current one is updated and, if enabled, written back,
//   unless m_axis stalls. The first button's record is read when the input
//   beat is accepted; it is then updated and registered in the output register.
//   s_axis_tready stays low while an update is being worked through; it
//   rises once the last button has been handed to the output register, even
//   if that beat is still waiting. A stalled m_axis freezes the work, the
//   RAM read data is held, and nothing is lost.
//   Reset returns the registers to their defaults and marks every RAM slot
//   as fresh (released, all times zero) at once; no clearing pass is needed.
//   Configuration writes go through cfg_we / cfg_addr / cfg_wdata; the user must
//   make them while no update is in progress, as the block does not enforce it.
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: now_ms [31:0], pin_levels [39:32]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bdlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tdata: button_index [2:0], event_res [5:3], is_pressed [6], zero [7]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: not_enabled [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [bdlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bdlp_pkg::*;

  localparam int EffButtons = (NUM_BUTTONS < MAX_BUTTONS) ? NUM_BUTTONS : MAX_BUTTONS;
  localparam int IdxW       = (EffButtons > 1) ? $clog2(EffButtons) : 1;
  localparam int StateW     = $bits(btn_state_t);

  // Configuration registers
  timing_t              timing;
  logic [COUNT_W-1:0]   buttons_in_use;
  logic [PINS_W-1:0]    enabled_mask;

  // Update context
  logic [NOW_W-1:0]     now_ms;
  logic [PINS_W-1:0]    pin_levels;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   eff_count;
  logic                 pvalid;
  logic [IdxW-1:0]      proc_idx;
  logic [COUNT_W-1:0]   nxt_idx;
  logic                 more;

  // Memory side
  logic                 slot_vld [EffButtons];
  logic                 rd_vld;
  logic                 rd_en;
  logic [IdxW-1:0]      raddr;
  logic                 wr_en;
  logic [StateW-1:0]    ram_rdata;
  btn_state_t           cur_state;
  btn_state_t           new_state;
  event_t               new_event;

  logic                 accept;
  logic                 step;
  logic                 enabled;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce_ms   <= MS_W'(50);
      timing.long_press_ms <= MS_W'(1000);
      timing.repeat_ms     <= MS_W'(200);
      buttons_in_use       <= COUNT_W'(8);
      enabled_mask         <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE:   timing.debounce_ms   <= cfg_wdata;
        REG_LONG_PRESS: timing.long_press_ms <= cfg_wdata;
        REG_REPEAT:     timing.repeat_ms     <= cfg_wdata;
        REG_COUNT:      buttons_in_use       <= cfg_wdata[COUNT_W-1:0];
        REG_ENABLE:     enabled_mask         <= cfg_wdata[PINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the button count
  assign eff_count = (buttons_in_use > COUNT_W'(EffButtons)) ? COUNT_W'(EffButtons)
                                                             : buttons_in_use;

  // Handshake and sequencing
  assign s_axis_tready = ~pvalid;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign step          = pvalid & (~m_axis_tvalid | m_axis_tready);
  assign nxt_idx       = COUNT_W'(proc_idx) + COUNT_W'(1);
  assign more          = nxt_idx < count;
  assign rd_en         = (accept && (eff_count != '0)) || (step && more);
  assign raddr         = accept ? '0 : nxt_idx[IdxW-1:0];
  assign enabled       = enabled_mask[proc_idx];
  assign wr_en         = step & enabled;

  // Latch the update beat and walk the buttons
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid   <= 1'b0;
      proc_idx <= '0;
    end else if (accept) begin
      pvalid   <= eff_count != '0;
      proc_idx <= '0;
    end else if (step) begin
      pvalid   <= more;
      proc_idx <= nxt_idx[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_ms     <= s_axis_tdata[NOW_W-1:0];
      pin_levels <= s_axis_tdata[NOW_W +: PINS_W];
      count      <= eff_count;
    end
  end

  // Track which slots have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EffButtons; i++) begin
        slot_vld[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_vld[proc_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= slot_vld[raddr];
      end
    end
  end

  bdlp_ram #(
    .WIDTH (StateW),
    .DEPTH (EffButtons),
    .AW    (IdxW)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (proc_idx),
    .wdata (new_state),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Fresh slots read as the reset record
  assign cur_state = rd_vld ? btn_state_t'(ram_rdata) : BTN_RESET;

  bdlp_update u_update (
    .timing    (timing),
    .now_ms    (now_ms),
    .raw       (pin_levels[proc_idx]),
    .state_in  (cur_state),
    .state_out (new_state),
    .event_res (new_event)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata[2:0] <= 3'(proc_idx);
      m_axis_tdata[5:3] <= enabled ? new_event : EV_NONE;
      m_axis_tdata[6]   <= enabled ? new_state.debounced_pressed
                                   : cur_state.debounced_pressed;
      m_axis_tdata[7]   <= 1'b0;
      m_axis_tuser      <= ~enabled;
      m_axis_tlast      <= ~more;
    end
  end

endmodule

// ----- src/bdlp_ram.sv -----
// ----------------------------------------------------------------------------
// bdlp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bdlp_update.sv -----
// ----------------------------------------------------------------------------
// bdlp_update
// Read-modify step for one button: debounce, press/release and long press.
// ----------------------------------------------------------------------------
module bdlp_update (
  input  bdlp_pkg::timing_t                 timing,
  input  logic [bdlp_pkg::NOW_W-1:0]        now_ms,
  input  logic                              raw,
  input  bdlp_pkg::btn_state_t              state_in,
  output bdlp_pkg::btn_state_t              state_out,
  output bdlp_pkg::event_t                  event_res
);
  import bdlp_pkg::*;

  logic             raw_changed;
  logic [NOW_W-1:0] stable_for;
  logic [NOW_W-1:0] held_for;
  logic [NOW_W-1:0] since_repeat;
  logic             pressed;
  logic             settled;

  // Time differences, all modulo 2^32
  assign raw_changed  = raw != state_in.raw_previous;
  assign stable_for   = raw_changed ? '0 : (now_ms - state_in.change_time);
  assign held_for     = now_ms - state_in.press_start_time;
  assign since_repeat = now_ms - state_in.repeat_time;
  assign pressed      = ~raw;
  assign settled      = stable_for >= NOW_W'(timing.debounce_ms);

  // Decide the event and the new record
  always_comb begin
    state_out              = state_in;
    event_res              = EV_NONE;
    state_out.raw_previous = raw;
    if (raw_changed) begin
      state_out.change_time = now_ms;
    end
    if (settled && (pressed != state_in.debounced_pressed)) begin
      state_out.debounced_pressed = pressed;
      if (pressed) begin
        state_out.press_start_time = now_ms;
        state_out.long_active      = 1'b0;
        state_out.repeat_time      = '0;
        event_res                  = EV_PRESS;
      end else begin
        event_res = state_in.long_active ? EV_RELEASE_LONG : EV_CLICK;
      end
    end else if (state_in.debounced_pressed) begin
      if (!state_in.long_active && (held_for >= NOW_W'(timing.long_press_ms))) begin
        state_out.long_active = 1'b1;
        state_out.repeat_time = now_ms;
        event_res             = EV_LONG;
      end else if (state_in.long_active &&
                   (since_repeat >= NOW_W'(timing.repeat_ms))) begin
        state_out.repeat_time = now_ms;
        event_res             = EV_REPEAT;
      end
    end
  end

endmodule

// ----- src/bdlp_checker.sv -----
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of the button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module bdlp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);
  import bdlp_pkg::*;

  // Hold a stalled result beat
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // Skipped buttons carry no event
  a_skip_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:3] == EV_NONE)
    else $error("event on a disabled button");

  // Press-type events come with the button down, release events with it up
  a_event_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata[5:3] != EV_PRESS && m_axis_tdata[5:3] != EV_LONG &&
        m_axis_tdata[5:3] != EV_REPEAT) || m_axis_tdata[6]) &&
      ((m_axis_tdata[5:3] != EV_CLICK && m_axis_tdata[5:3] != EV_RELEASE_LONG) ||
       !m_axis_tdata[6]))
    else $error("event disagrees with debounced state");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
